@@ src/icalc_pkg.sv @@
`timescale 1ns / 1ps

package icalc_pkg;

	// word width of every number in the expression
	localparam int WORD_BITS = 48;

	// sticky error bit positions
	localparam int ERR_DIV0 = 0;
	localparam int ERR_OVF  = 1;

	// saturation limits
	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// operator that follows an operand
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_code_t;

	// pending additive operator
	typedef enum logic [1:0] {
		ADD_NONE  = 2'd0,
		ADD_PLUS  = 2'd1,
		ADD_MINUS = 2'd2
	} add_pend_t;

	// pending multiplicative operator
	typedef enum logic [1:0] {
		MUL_NONE   = 2'd0,
		MUL_TIMES  = 2'd1,
		MUL_DIVIDE = 2'd2
	} mul_pend_t;

	// input beat
	typedef struct packed {
		logic signed [WORD_BITS-1:0] operand_value;
		logic [1:0]                  operation;
		logic                        is_last;
	} operand_t;

	// output beat
	typedef struct packed {
		logic signed [WORD_BITS-1:0] result_value;
		logic                        divide_by_zero;
		logic                        overflowed;
	} result_t;

endpackage

@@ src/infix_two_level_calculator_unit.sv @@
// Infix calculator over signed fixed-point words (FRACTION_BITS fraction bits).
// Operand channel: one beat per number, carrying the operator that follows it
// or an end mark. Result channel: one beat per expression, sent after the
// beat marked last, with the value and sticky divide-by-zero and overflow flags.
// Multiply and divide bind tighter than add and subtract; equal levels go left
// to right. One shared adder does the multiply, divide, saturation and sum work.
// operand_stall stays high while a beat is processed: the sequencer goes
// through IDLE and POST for a beat with no pending multiply/divide, through
// MUL (one shift-add step per cycle) and SAT for a pending multiply, and
// through DIV (one restoring quotient bit per cycle) and SAT for a pending
// divide; a zero divisor skips straight to POST. The last beat also passes
// through EMIT, where it waits for any stalled result.
// result_valid rises when EMIT loads the result register.
// The result sits in an output register; the block keeps taking operands while
// it waits, and only a finished expression waits when result_stall holds the
// previous result. Reset clears the running sum, term, pending operators and
// flags, and leaves the result channel empty.
`timescale 1ns / 1ps

module infix_two_level_calculator_unit #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                operand_valid,
	output logic                operand_stall,
	input  icalc_pkg::operand_t operand,
	output logic                result_valid,
	input  logic                result_stall,
	output icalc_pkg::result_t  result
);

	localparam int W  = icalc_pkg::WORD_BITS;
	localparam int DW = W + FRACTION_BITS;
	localparam int PW = 2 * W;
	localparam int QW = (PW > DW) ? PW : DW;
	localparam int AW = W + 2;
	localparam int CW = $clog2(DW);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_SAT  = 6'b001000,
		ST_POST = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [W-1:0]           sum_q;
	icalc_pkg::add_pend_t   padd_q;
	logic [W-1:0]           term_q;
	icalc_pkg::mul_pend_t   pmul_q;
	logic [1:0]             err_q;
	logic [W-1:0]           opnd_q;
	logic [W-1:0]           acc_q;
	logic [W-1:0]           lo_q;
	logic [DW-1:0]          dq_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   last_q;
	logic [1:0]             op_q;
	logic                   result_valid_q;
	icalc_pkg::result_t     result_q;

	// two's complement magnitude of a word
	function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
		return x[W-1] ? (~x + W'(1)) : x;
	endfunction

	logic         accept;
	logic         take;
	logic         load;
	logic [W-1:0] op_mag;
	logic [W-1:0] term_mag;

	assign accept   = operand_valid && !operand_stall;
	assign take     = result_valid_q && !result_stall;
	assign load     = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);
	assign op_mag   = mag_of(operand.operand_value);
	assign term_mag = mag_of(term_q);

	assign operand_stall = (state_q != ST_IDLE);
	assign result_valid  = result_valid_q;
	assign result        = result_q;

	// saturation check of the product or quotient magnitude
	logic [QW-1:0] sat_mag;
	logic [QW-1:0] sat_upper;
	logic          sat_over;

	assign sat_mag   = (pmul_q == icalc_pkg::MUL_TIMES) ?
		QW'({acc_q, lo_q} >> FRACTION_BITS) : QW'(dq_q);
	assign sat_upper = sat_mag >> (W - 1);
	assign sat_over  = neg_q ?
		((sat_upper > QW'(1)) || ((sat_upper == QW'(1)) && (sat_mag[W-2:0] != '0))) :
		(sat_upper != '0);

	// shared adder operand selection
	logic [AW-1:0] add_a;
	logic [AW-1:0] add_b;
	logic          add_ci;
	logic [AW-1:0] add_r;
	logic [W:0]    rem_sh;
	logic          fold_sub;

	assign rem_sh   = {acc_q, dq_q[DW-1]};
	assign fold_sub = (padd_q == icalc_pkg::ADD_MINUS);

	always_comb begin
		add_a  = '0;
		add_b  = '0;
		add_ci = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				add_a = AW'(acc_q);
				add_b = lo_q[0] ? AW'(opnd_q) : '0;
			end
			ST_DIV: begin
				add_a  = AW'(rem_sh);
				add_b  = ~AW'(opnd_q);
				add_ci = 1'b1;
			end
			ST_SAT: begin
				add_b  = ~AW'(sat_mag[W-1:0]);
				add_ci = 1'b1;
			end
			ST_POST: begin
				add_a  = {{2{sum_q[W-1]}}, sum_q};
				add_b  = fold_sub ? ~{{2{term_q[W-1]}}, term_q} : {{2{term_q[W-1]}}, term_q};
				add_ci = fold_sub;
			end
			default: begin
				add_a  = '0;
				add_b  = '0;
				add_ci = 1'b0;
			end
		endcase
	end

	assign add_r = add_a + add_b + AW'(add_ci);

	// derived adder results
	logic         div_ge;
	logic [W:0]   fold_r;
	logic         fold_ovf;
	logic         fold_needed;

	assign div_ge      = !add_r[AW-1];
	assign fold_r      = add_r[W:0];
	assign fold_ovf    = fold_r[W] ^ fold_r[W-1];
	assign fold_needed = last_q || (op_q == icalc_pkg::OP_ADD) || (op_q == icalc_pkg::OP_SUB);

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			padd_q  <= icalc_pkg::ADD_NONE;
			term_q  <= '0;
			pmul_q  <= icalc_pkg::MUL_NONE;
			err_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q  <= term_q[W-1] ^ operand.operand_value[W-1];
						opnd_q <= (pmul_q == icalc_pkg::MUL_TIMES) ? term_mag : op_mag;
						last_q <= operand.is_last;
						op_q   <= operand.operation;
						acc_q  <= '0;
						lo_q   <= op_mag;
						dq_q   <= DW'(term_mag) << FRACTION_BITS;
						case (pmul_q)
							icalc_pkg::MUL_TIMES: begin
								cnt_q   <= CW'(W - 1);
								state_q <= ST_MUL;
							end
							icalc_pkg::MUL_DIVIDE: begin
								if (operand.operand_value == '0) begin
									term_q                   <= '0;
									err_q[icalc_pkg::ERR_DIV0] <= 1'b1;
									state_q                  <= ST_POST;
								end else begin
									cnt_q   <= CW'(DW - 1);
									state_q <= ST_DIV;
								end
							end
							default: begin
								term_q  <= operand.operand_value;
								state_q <= ST_POST;
							end
						endcase
					end
				end
				ST_MUL: begin
					acc_q <= add_r[W:1];
					lo_q  <= {add_r[0], lo_q[W-1:1]};
					if (cnt_q == '0) begin
						state_q <= ST_SAT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_DIV: begin
					acc_q <= div_ge ? add_r[W-1:0] : rem_sh[W-1:0];
					dq_q  <= {dq_q[DW-2:0], div_ge};
					if (cnt_q == '0) begin
						state_q <= ST_SAT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_SAT: begin
					if (sat_over) begin
						term_q                    <= neg_q ? icalc_pkg::WORD_MIN : icalc_pkg::WORD_MAX;
						err_q[icalc_pkg::ERR_OVF] <= 1'b1;
					end else begin
						term_q <= neg_q ? add_r[W-1:0] : sat_mag[W-1:0];
					end
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (fold_needed) begin
						// fold the finished term into the sum
						pmul_q <= icalc_pkg::MUL_NONE;
						if (padd_q == icalc_pkg::ADD_NONE) begin
							sum_q <= term_q;
						end else if (fold_ovf) begin
							sum_q <= fold_r[W] ? icalc_pkg::WORD_MIN : icalc_pkg::WORD_MAX;
							err_q[icalc_pkg::ERR_OVF] <= 1'b1;
						end else begin
							sum_q <= fold_r[W-1:0];
						end
						if (last_q) begin
							state_q <= ST_EMIT;
						end else begin
							padd_q  <= (op_q == icalc_pkg::OP_ADD) ?
								icalc_pkg::ADD_PLUS : icalc_pkg::ADD_MINUS;
							state_q <= ST_IDLE;
						end
					end else begin
						pmul_q  <= (op_q == icalc_pkg::OP_MUL) ?
							icalc_pkg::MUL_TIMES : icalc_pkg::MUL_DIVIDE;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load) begin
						sum_q   <= '0;
						padd_q  <= icalc_pkg::ADD_NONE;
						term_q  <= '0;
						pmul_q  <= icalc_pkg::MUL_NONE;
						err_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (take) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.result_value   <= sum_q;
			result_q.divide_by_zero <= err_q[icalc_pkg::ERR_DIV0];
			result_q.overflowed     <= err_q[icalc_pkg::ERR_OVF];
		end
	end

	// iteration counter steps down by one while the loop runs
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MUL) || (state_q == ST_DIV)) && (cnt_q != '0)
		|=> (state_q == $past(state_q)) && (cnt_q == $past(cnt_q) - CW'(1)))
	else $error("iteration counter did not step");

	// partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (acc_q < opnd_q))
	else $error("partial remainder not below divisor");

	// a zero divisor raises the sticky flag
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (pmul_q == icalc_pkg::MUL_DIVIDE) && (operand.operand_value == '0)
		|=> err_q[icalc_pkg::ERR_DIV0])
	else $error("zero divisor not flagged");

	// sending a result returns the expression state to its cleared form
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q == ST_IDLE) && (padd_q == icalc_pkg::ADD_NONE)
			&& (pmul_q == icalc_pkg::MUL_NONE) && (err_q == '0) && result_valid_q)
	else $error("state not cleared after result");

endmodule
